>>> rtl/sab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_pkg
// Shared constants, opcodes and types for the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int P_MAX_TEXT = 256;
	localparam int P_ALPHABET = 256;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_MATCH  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// per-field write enables of the node attribute store
	typedef struct packed {
		logic len;
		logic link;
		logic fpos;
	} node_we_t;

endpackage
`default_nettype wire

>>> rtl/sab_trans_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_trans_mem
// Transition table: one write port, one registered read port.
// Entry is 0 when absent, otherwise target state plus one.
// ----------------------------------------------------------------------------
module sab_trans_mem #(
	parameter int AW = 17,
	parameter int EW = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [EW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [EW-1:0] rd_data
);
	logic [EW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> rtl/sab_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sab_node_mem
// Per-state attributes: longest length, suffix link, first end position.
// ----------------------------------------------------------------------------
module sab_node_mem #(
	parameter int ST_W  = 9,
	parameter int LEN_W = 9,
	parameter int LNK_W = 10,
	parameter int FP_W  = 10
) (
	input  wire logic                    clk,
	input  wire sab_pkg::node_we_t       wr_en,
	input  wire logic        [ST_W-1:0]  wr_addr,
	input  wire logic        [LEN_W-1:0] wr_len,
	input  wire logic signed [LNK_W-1:0] wr_link,
	input  wire logic signed [FP_W-1:0]  wr_fpos,
	input  wire logic        [ST_W-1:0]  rd_addr,
	output logic             [LEN_W-1:0] rd_len,
	output logic signed      [LNK_W-1:0] rd_link,
	output logic signed      [FP_W-1:0]  rd_fpos
);
	import sab_pkg::*;

	logic        [LEN_W-1:0] len_mem  [(1 << ST_W)];
	logic signed [LNK_W-1:0] link_mem [(1 << ST_W)];
	logic signed [FP_W-1:0]  fpos_mem [(1 << ST_W)];

	always_ff @(posedge clk) begin
		if (wr_en.len) begin
			len_mem[wr_addr] <= wr_len;
		end
		if (wr_en.link) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (wr_en.fpos) begin
			fpos_mem[wr_addr] <= wr_fpos;
		end
		rd_len  <= len_mem[rd_addr];
		rd_link <= link_mem[rd_addr];
		rd_fpos <= fpos_mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> rtl/suffix_automaton_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction with pattern match stepping.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  opcode, symbol, pattern_start
//   out      out  out_valid/out_stall node, node_len, node_link,
//                                    node_first_pos, found, full_error,
//                                    node_count
//
// One transaction at a time. Append: clear the new row, step along suffix
// links, and on a clone copy the row through the single transition port.
// Match step: one transition lookup and a node attribute read; the read is
// skipped on a missing transition, and both when the pattern is already dead.
// Clear: sweep row 0. After reset the same row 0 sweep runs before the
// first transaction is taken.
// A stalled result holds in the output register; the next input waits.
// ----------------------------------------------------------------------------
module suffix_automaton_builder #(
	parameter int MAX_TEXT = sab_pkg::P_MAX_TEXT,
	parameter int ALPHABET = sab_pkg::P_ALPHABET
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  symbol,
	input  wire logic        pattern_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [8:0]       node,
	output logic [8:0]       node_len,
	output logic signed [9:0] node_link,
	output logic signed [8:0] node_first_pos,
	output logic             found,
	output logic             full_error,
	output logic [9:0]       node_count
);
	import sab_pkg::*;

	localparam int ST_W  = $clog2(2 * MAX_TEXT);
	localparam int LEN_W = $clog2(MAX_TEXT + 1);
	localparam int LNK_W = ST_W + 1;
	localparam int FP_W  = LEN_W + 1;
	localparam int SYM_W = $clog2(ALPHABET);
	localparam int AW    = ST_W + SYM_W;
	localparam int EW    = ST_W + 1;
	localparam int CW    = SYM_W + 1;

	typedef enum logic [17:0] {
		S_INIT = 18'h00001,
		S_IDLE = 18'h00002,
		S_CLR  = 18'h00004,
		S_WRD  = 18'h00008,
		S_WCHK = 18'h00010,
		S_QCHK = 18'h00020,
		S_CLW2 = 18'h00040,
		S_CLW3 = 18'h00080,
		S_COPY = 18'h00100,
		S_RRD  = 18'h00200,
		S_RCHK = 18'h00400,
		S_FIN  = 18'h00800,
		S_MRD  = 18'h01000,
		S_MCHK = 18'h02000,
		S_ORD  = 18'h04000,
		S_OCAP = 18'h08000,
		S_EMIT = 18'h10000,
		S_SPARE = 18'h20000
	} state_t;

	state_t state_q;

	logic [ST_W-1:0]  last_q, total_q, ws_q, cur_q, p_q, q_q, cl_q, rep_q;
	logic [LEN_W-1:0] text_q, lenp_q;
	logic             dead_q, init_emit_q;
	logic [SYM_W-1:0] sym_q;
	logic [CW-1:0]    cnt_q;

	logic [8:0]        res_node_q, res_len_q;
	logic signed [9:0] res_link_q;
	logic signed [8:0] res_fpos_q;
	logic              res_found_q, res_full_q;

	logic          t_we;
	logic [AW-1:0] t_waddr, t_raddr;
	logic [EW-1:0] t_wdata, t_rdata;

	node_we_t                n_we;
	logic [ST_W-1:0]         n_waddr, n_raddr;
	logic [LEN_W-1:0]        n_wlen, n_rlen;
	logic signed [LNK_W-1:0] n_wlink, n_rlink;
	logic signed [FP_W-1:0]  n_wfpos, n_rfpos;

	logic             accept, emit_go, sym_bad, full_now;
	logic [SYM_W-1:0] cnt_idx, cnt_prev;
	logic [EW-1:0]    cur_entry, cl_entry, q_entry;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign emit_go   = (state_q == S_EMIT) && (!out_valid || !out_stall);
	assign sym_bad   = 9'(symbol) >= 9'(ALPHABET);
	assign full_now  = text_q == LEN_W'(MAX_TEXT);
	assign cnt_idx   = cnt_q[SYM_W-1:0];
	assign cnt_prev  = SYM_W'(cnt_q - CW'(1));
	assign cur_entry = EW'(cur_q) + EW'(1);
	assign cl_entry  = EW'(cl_q) + EW'(1);
	assign q_entry   = EW'(q_q) + EW'(1);

	sab_trans_mem #(.AW(AW), .EW(EW)) u_trans (
		.clk     (clk),
		.wr_en   (t_we),
		.wr_addr (t_waddr),
		.wr_data (t_wdata),
		.rd_addr (t_raddr),
		.rd_data (t_rdata)
	);

	sab_node_mem #(.ST_W(ST_W), .LEN_W(LEN_W), .LNK_W(LNK_W), .FP_W(FP_W)) u_node (
		.clk     (clk),
		.wr_en   (n_we),
		.wr_addr (n_waddr),
		.wr_len  (n_wlen),
		.wr_link (n_wlink),
		.wr_fpos (n_wfpos),
		.rd_addr (n_raddr),
		.rd_len  (n_rlen),
		.rd_link (n_rlink),
		.rd_fpos (n_rfpos)
	);

	always_comb begin
		t_we    = 1'b0;
		t_waddr = {p_q, sym_q};
		t_wdata = '0;
		t_raddr = {p_q, sym_q};
		n_we    = '0;
		n_waddr = cur_q;
		n_wlen  = '0;
		n_wlink = '0;
		n_wfpos = '0;
		n_raddr = p_q;
		case (state_q)
			S_INIT: begin
				t_we    = 1'b1;
				t_waddr = {ST_W'(0), cnt_idx};
				n_we    = '{len: 1'b1, link: 1'b1, fpos: 1'b1};
				n_waddr = '0;
				n_wlink = '1;
				n_wfpos = '1;
			end
			S_CLR: begin
				t_we    = 1'b1;
				t_waddr = {cur_q, cnt_idx};
				if (cnt_q == '0) begin
					n_we    = '{len: 1'b1, link: 1'b1, fpos: 1'b1};
					n_wlen  = text_q + LEN_W'(1);
					n_wfpos = $signed({1'b0, text_q});
				end
			end
			S_WCHK: begin
				n_raddr = ST_W'(t_rdata - EW'(1));
				if (t_rdata == '0) begin
					t_we    = 1'b1;
					t_wdata = cur_entry;
				end
			end
			S_QCHK: begin
				if (lenp_q + LEN_W'(1) == n_rlen) begin
					n_we.link = 1'b1;
					n_wlink   = $signed({1'b0, q_q});
				end else begin
					n_we    = '{len: 1'b1, link: 1'b1, fpos: 1'b1};
					n_waddr = total_q;
					n_wlen  = lenp_q + LEN_W'(1);
					n_wlink = n_rlink;
					n_wfpos = n_rfpos;
				end
			end
			S_CLW2: begin
				n_we.link = 1'b1;
				n_waddr   = q_q;
				n_wlink   = $signed({1'b0, cl_q});
			end
			S_CLW3: begin
				n_we.link = 1'b1;
				n_wlink   = $signed({1'b0, cl_q});
			end
			S_COPY: begin
				t_raddr = {q_q, cnt_idx};
				t_waddr = {cl_q, cnt_prev};
				t_wdata = t_rdata;
				t_we    = (cnt_q != '0);
			end
			S_RCHK: begin
				if (t_rdata == q_entry) begin
					t_we    = 1'b1;
					t_wdata = cl_entry;
				end
			end
			S_ORD: begin
				n_raddr = rep_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			init_emit_q <= 1'b0;
			last_q      <= '0;
			total_q     <= ST_W'(1);
			text_q      <= '0;
			ws_q        <= '0;
			dead_q      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ALPHABET - 1)) begin
						if (init_emit_q) begin
							res_node_q  <= '0;
							res_len_q   <= '0;
							res_link_q  <= '1;
							res_fpos_q  <= '1;
							res_found_q <= 1'b0;
							res_full_q  <= 1'b0;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						res_full_q  <= (opcode == OP_APPEND) && full_now;
						sym_q       <= symbol[SYM_W-1:0];
						cnt_q       <= '0;
						case (opcode)
							OP_APPEND: begin
								if (full_now || sym_bad) begin
									rep_q   <= last_q;
									state_q <= S_ORD;
								end else begin
									cur_q   <= total_q;
									total_q <= total_q + ST_W'(1);
									p_q     <= last_q;
									state_q <= S_CLR;
								end
							end
							OP_MATCH: begin
								if ((!pattern_start && dead_q) || sym_bad) begin
									dead_q     <= 1'b1;
									res_node_q <= '0;
									res_len_q  <= '0;
									res_link_q <= '0;
									res_fpos_q <= '0;
									state_q    <= S_EMIT;
								end else begin
									p_q     <= pattern_start ? '0 : ws_q;
									dead_q  <= 1'b0;
									state_q <= S_MRD;
								end
							end
							OP_CLEAR: begin
								last_q      <= '0;
								total_q     <= ST_W'(1);
								text_q      <= '0;
								ws_q        <= '0;
								dead_q      <= 1'b0;
								init_emit_q <= 1'b1;
								state_q     <= S_INIT;
							end
							default: begin
								res_node_q <= '0;
								res_len_q  <= '0;
								res_link_q <= '1;
								res_fpos_q <= '1;
								state_q    <= S_EMIT;
							end
						endcase
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ALPHABET - 1)) begin
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (t_rdata == '0) begin
						p_q <= n_rlink[ST_W-1:0];
						state_q <= n_rlink[LNK_W-1] ? S_FIN : S_WRD;
					end else begin
						q_q     <= ST_W'(t_rdata - EW'(1));
						lenp_q  <= n_rlen;
						state_q <= S_QCHK;
					end
				end
				S_QCHK: begin
					if (lenp_q + LEN_W'(1) == n_rlen) begin
						state_q <= S_FIN;
					end else begin
						cl_q    <= total_q;
						total_q <= total_q + ST_W'(1);
						state_q <= S_CLW2;
					end
				end
				S_CLW2: begin
					state_q <= S_CLW3;
				end
				S_CLW3: begin
					cnt_q   <= '0;
					state_q <= S_COPY;
				end
				S_COPY: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ALPHABET)) begin
						state_q <= S_RRD;
					end
				end
				S_RRD: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (t_rdata == q_entry) begin
						p_q <= n_rlink[ST_W-1:0];
						state_q <= n_rlink[LNK_W-1] ? S_FIN : S_RRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					last_q  <= cur_q;
					text_q  <= text_q + LEN_W'(1);
					rep_q   <= cur_q;
					state_q <= S_ORD;
				end
				S_MRD: begin
					state_q <= S_MCHK;
				end
				S_MCHK: begin
					if (t_rdata == '0) begin
						dead_q     <= 1'b1;
						ws_q       <= p_q;
						res_node_q <= '0;
						res_len_q  <= '0;
						res_link_q <= '0;
						res_fpos_q <= '0;
						state_q    <= S_EMIT;
					end else begin
						ws_q        <= ST_W'(t_rdata - EW'(1));
						rep_q       <= ST_W'(t_rdata - EW'(1));
						res_found_q <= 1'b1;
						state_q     <= S_ORD;
					end
				end
				S_ORD: begin
					state_q <= S_OCAP;
				end
				S_OCAP: begin
					res_node_q <= 9'(rep_q);
					res_len_q  <= 9'(n_rlen);
					res_link_q <= 10'(n_rlink);
					res_fpos_q <= 9'(n_rfpos);
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						init_emit_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			node           <= res_node_q;
			node_len       <= res_len_q;
			node_link      <= res_link_q;
			node_first_pos <= res_fpos_q;
			found          <= res_found_q;
			full_error     <= res_full_q;
			node_count     <= 10'(total_q);
		end
	end
endmodule
`default_nettype wire

>>> verif/suffix_automaton_builder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder_test
// Drives append, match-step, clear and unused-opcode transactions into the
// suffix automaton builder with random idling on both sides. Every result is
// checked field by field against an in-bench model of the automaton.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_test;
	import sab_pkg::*;

	localparam int NSTATES = 2 * P_MAX_TEXT;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG = 200000;
	localparam int N_RANDOM = 1172;

	typedef struct packed {
		logic [8:0] node;
		logic [8:0] len;
		logic signed [9:0] link;
		logic signed [8:0] fpos;
		logic found;
		logic full;
		logic [9:0] count;
	} sam_result_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] sym;
		logic start;
		logic typed;
		sam_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] opcode = OP_APPEND;
	logic [7:0] symbol = '0;
	logic pattern_start = 1'b0;
	logic out_stall = 1'b1;
	wire in_stall, out_valid, found, full_error;
	wire [8:0] node, node_len;
	wire signed [9:0] node_link;
	wire signed [8:0] node_first_pos;
	wire [9:0] node_count;

	suffix_automaton_builder u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .symbol(symbol), .pattern_start(pattern_start),
		.out_valid(out_valid), .out_stall(out_stall), .node(node),
		.node_len(node_len), .node_link(node_link),
		.node_first_pos(node_first_pos), .found(found),
		.full_error(full_error), .node_count(node_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// automaton mirror: goto holds node+1, 0 when absent
	logic [9:0] sam_goto [NSTATES][P_ALPHABET];
	logic [8:0] sam_len [NSTATES];
	int sam_link [NSTATES];
	int sam_fpos [NSTATES];
	int sam_last, sam_total, sam_textlen, walk_node;
	bit walk_dead;

	sam_result_t results_due[$];
	int errors = 0;
	bit hold_receiver = 1'b0;
	bit stim_done = 1'b0;
	int idle_cycles = 0;

	function automatic sam_result_t describe_node(int st, bit fnd, bit full);
		sam_result_t r;
		r.node = st[8:0];
		r.len = sam_len[st];
		r.link = sam_link[st][9:0];
		r.fpos = sam_fpos[st][8:0];
		r.found = fnd;
		r.full = full;
		r.count = sam_total[9:0];
		return r;
	endfunction

	function automatic void reset_to_root();
		for (int a = 0; a < P_ALPHABET; a++) sam_goto[0][a] = '0;
		sam_len[0] = '0;
		sam_link[0] = -1;
		sam_fpos[0] = -1;
		sam_last = 0;
		sam_total = 1;
		sam_textlen = 0;
		walk_node = 0;
		walk_dead = 1'b0;
	endfunction

	function automatic void extend_text(int c);
		int cur, p, q, cl;
		cur = sam_total++;
		p = sam_last;
		for (int a = 0; a < P_ALPHABET; a++) sam_goto[cur][a] = '0;
		sam_len[cur] = 9'(sam_textlen + 1);
		sam_link[cur] = 0;
		sam_fpos[cur] = sam_textlen;
		while (p >= 0 && sam_goto[p][c] == 0) begin
			sam_goto[p][c] = 10'(cur + 1);
			p = sam_link[p];
		end
		if (p >= 0) begin
			q = sam_goto[p][c] - 1;
			if (sam_len[p] + 1 == sam_len[q]) begin
				sam_link[cur] = q;
			end else begin
				cl = sam_total++;
				sam_goto[cl] = sam_goto[q];
				sam_len[cl] = 9'(sam_len[p] + 1);
				sam_link[cl] = sam_link[q];
				sam_fpos[cl] = sam_fpos[q];
				sam_link[q] = cl;
				sam_link[cur] = cl;
				while (p >= 0 && sam_goto[p][c] == 10'(q + 1)) begin
					sam_goto[p][c] = 10'(cl + 1);
					p = sam_link[p];
				end
			end
		end
		sam_last = cur;
		sam_textlen++;
	endfunction

	function automatic sam_result_t apply_transaction(logic [1:0] op, logic [7:0] sym,
			logic st);
		sam_result_t r;
		logic [9:0] e;
		case (op)
			OP_APPEND: begin
				if (sam_textlen >= P_MAX_TEXT) return describe_node(sam_last, 0, 1);
				extend_text(sym);
				r = describe_node(sam_last, 0, 0);
			end
			OP_MATCH: begin
				if (st) begin
					walk_node = 0;
					walk_dead = 1'b0;
				end
				e = walk_dead ? 10'd0 : sam_goto[walk_node][sym];
				if (e == 0) begin
					walk_dead = 1'b1;
					r = '0;
					r.count = sam_total[9:0];
				end else begin
					walk_node = e - 1;
					r = describe_node(walk_node, 1, 0);
				end
			end
			OP_CLEAR: begin
				reset_to_root();
				r = describe_node(0, 0, 0);
			end
			default: r = describe_node(0, 0, 0);
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic sam_result_t root_result(int cnt, bit full);
		sam_result_t r;
		r.node = '0;
		r.len = '0;
		r.link = -10'sd1;
		r.fpos = -9'sd1;
		r.found = 1'b0;
		r.full = full;
		r.count = 10'(cnt);
		return r;
	endfunction

	task automatic send_transaction(logic [1:0] op, logic [7:0] sym, logic st);
		opcode <= op;
		symbol <= sym;
		pattern_start <= st;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		results_due.push_back(apply_transaction(op, sym, st));
		idle_cycles = 0;
	endtask

	task automatic send_with_gap(logic [1:0] op, logic [7:0] sym, logic st);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_transaction(op, sym, st);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	stim_row_t directed [] = '{
		'{OP_UNUSED, 8'h00, 1'b0, 1'b1, root_result(1, 0)},
		'{OP_MATCH, 8'h00, 1'b1, 1'b1, sam_result_t'{0, 0, 0, 0, 0, 0, 10'd1}},
		'{OP_APPEND, 8'h00, 1'b0, 1'b0, '0},
		'{OP_APPEND, 8'hFF, 1'b0, 1'b0, '0},
		'{OP_APPEND, 8'h00, 1'b0, 1'b0, '0},
		'{OP_APPEND, 8'hFF, 1'b0, 1'b0, '0},
		'{OP_APPEND, 8'h00, 1'b0, 1'b0, '0},
		'{OP_APPEND, 8'h00, 1'b0, 1'b0, '0},
		'{OP_MATCH, 8'h00, 1'b1, 1'b0, '0},
		'{OP_MATCH, 8'hFF, 1'b0, 1'b0, '0},
		'{OP_MATCH, 8'h00, 1'b0, 1'b0, '0},
		'{OP_MATCH, 8'hAA, 1'b0, 1'b0, '0},
		'{OP_MATCH, 8'h00, 1'b0, 1'b0, '0},
		'{OP_MATCH, 8'h00, 1'b1, 1'b0, '0},
		'{OP_UNUSED, 8'h55, 1'b1, 1'b0, '0},
		'{OP_CLEAR, 8'hFF, 1'b1, 1'b1, root_result(1, 0)},
		'{OP_MATCH, 8'h00, 1'b1, 1'b1, sam_result_t'{0, 0, 0, 0, 0, 0, 10'd1}},
		'{OP_APPEND, 8'h61, 1'b1, 1'b0, '0},
		'{OP_MATCH, 8'h61, 1'b1, 1'b0, '0}
	};

	// result checker and receiver idling
	initial begin
		sam_result_t want, got;
		int g;
		wait (arst_n);
		forever begin
			g = hold_receiver ? 0 : pick_gap();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= hold_receiver;
			@(posedge clk);
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				got = '{node, node_len, node_link, node_first_pos, found, full_error,
					node_count};
				if (results_due.size() == 0) begin
					$error("unexpected transaction: node %0d", node);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (got.node !== want.node) begin
						$error("node: expected %0d, got %0d", want.node, got.node);
						errors++;
					end
					if (got.len !== want.len) begin
						$error("node_len: expected %0d, got %0d", want.len, got.len);
						errors++;
					end
					if (got.link !== want.link) begin
						$error("node_link: expected %0d, got %0d", want.link, got.link);
						errors++;
					end
					if (got.fpos !== want.fpos) begin
						$error("node_first_pos: expected %0d, got %0d", want.fpos,
							got.fpos);
						errors++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						errors++;
					end
					if (got.full !== want.full) begin
						$error("full_error: expected %0d, got %0d", want.full, got.full);
						errors++;
					end
					if (got.count !== want.count) begin
						$error("node_count: expected %0d, got %0d", want.count,
							got.count);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired");
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver hold-off while the sender keeps offering
	initial begin
		wait (stim_done == 1'b0 && arst_n);
		wait (results_due.size() >= 1);
		hold_receiver = 1'b1;
		repeat (3000) @(posedge clk);
		hold_receiver = 1'b0;
	end

	initial begin
		int k, len, src;
		logic [7:0] sym;
		logic [1:0] op;
		logic [7:0] text[$];
		reset_to_root();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_with_gap(directed[i].op, directed[i].sym, directed[i].start);
			if (directed[i].typed)
				results_due[results_due.size() - 1] = directed[i].res;
		end

		// fill the text to its limit, then check the full flag
		for (int i = sam_textlen; i < P_MAX_TEXT; i++)
			send_with_gap(OP_APPEND, 8'($urandom_range(0, 3)), 1'b0);
		send_with_gap(OP_APPEND, 8'hFF, 1'b1);
		results_due[results_due.size() - 1].full = 1'b1;
		send_with_gap(OP_MATCH, 8'h01, 1'b1);
		drain_results();
		send_with_gap(OP_CLEAR, 8'h00, 1'b0);

		k = 0;
		while (k < N_RANDOM) begin
			src = $urandom_range(0, 99);
			if (src < 3 || sam_textlen >= P_MAX_TEXT) begin
				send_with_gap(OP_CLEAR, 8'($urandom), 1'($urandom));
				text.delete();
				k++;
			end else if (src < 50) begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len && k < N_RANDOM; j++) begin
					sym = (src < 40) ? 8'($urandom_range(0, 3)) : 8'($urandom);
					send_with_gap(OP_APPEND, sym, 1'($urandom));
					if (sam_textlen > text.size()) text.push_back(sym);
					k++;
				end
			end else if (src < 95) begin
				// pattern taken from the text, sometimes corrupted
				len = $urandom_range(1, 6);
				src = text.size() ? $urandom_range(0, text.size() - 1) : 0;
				for (int j = 0; j < len && k < N_RANDOM; j++) begin
					sym = (src + j < text.size()) ? text[src + j] : 8'($urandom);
					if ($urandom_range(0, 9) == 0) sym = 8'($urandom);
					send_with_gap(OP_MATCH, sym, j == 0);
					k++;
				end
			end else begin
				op = ($urandom_range(0, 1)) ? OP_UNUSED : OP_MATCH;
				send_with_gap(op, 8'($urandom), 1'($urandom));
				k++;
			end
			if (k > 700 && k < 720) begin
				drain_results();
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
		drain_results();
		stim_done = 1'b1;
		repeat (50) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
